// File: rtl/core/clut_pkg.sv
// shared types and constants of the colormap lookup block
package clut_pkg;

  localparam int DEFAULT_TABLE_DEPTH     = 256;
  localparam int DEFAULT_VALUE_FRAC_BITS = 16;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 9;

  typedef enum logic [1:0] {
    REG_COLOR_MODE   = 2'd0,
    REG_MAP_KIND     = 2'd1,
    REG_ENTRY_COUNT  = 2'd2,
    REG_INVERT_ORDER = 2'd3
  } reg_idx_t;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef enum logic {
    MODE_GRAY  = 1'b0,
    MODE_COLOR = 1'b1
  } color_mode_t;

  // code 3 is unused and falls through to the table map
  localparam logic [1:0] MAP_RAINBOW = 2'd0;
  localparam logic [1:0] MAP_CATEG   = 2'd1;
  localparam logic [1:0] MAP_TABLE   = 2'd2;

  localparam logic               RST_COLOR_MODE   = 1'b1;
  localparam logic [1:0]         RST_MAP_KIND     = MAP_TABLE;
  localparam logic [COUNT_W-1:0] RST_ENTRY_COUNT  = 9'd256;
  localparam logic               RST_INVERT_ORDER = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_MIX
  } clut_state_t;

endpackage

// File: rtl/core/colormap_lookup_interp.sv
// pseudocolor lookup with rgb table, rainbow formula and linear interpolation
//
// a request with start high is taken whenever busy is low. a table write
// (func = 0) stores red_in/green_in/blue_in at entry_index in the same cycle
// and gives no result; the next request may follow in the very next cycle.
// a lookup (func = 1) walks a four-step sequence: the value is saturated and
// scaled by count-1, the one or two table entries are read from the color
// table (one synchronous memory, two read ports, one write port), the
// neighbors are blended, and the color shows on red/green/blue with done high
// for exactly one cycle; both are registered out of the mix state. busy is
// high in the calc, read and mix states, so a lookup must leave the mix
// state before the block takes another request of either kind. a new request
// can be taken in the cycle in which done is high. done cannot be held off:
// the receiver must take the result in that cycle. table writes and reads
// never overlap because writes only happen while the sequencer is idle, so
// no forwarding is needed. table entries are undefined until written; there
// is no clearing pass after reset. configuration (apb, registers at 4*index)
// must only be written while the block is idle.
module colormap_lookup_interp
  import clut_pkg::*;
#(
  parameter int TABLE_DEPTH     = DEFAULT_TABLE_DEPTH,
  parameter int VALUE_FRAC_BITS = DEFAULT_VALUE_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // request side
  input  logic                  start,
  output logic                  busy,
  input  logic                  func,
  input  logic [7:0]            entry_index,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  input  logic [23:0]           sample_value,
  // result side
  output logic                  done,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // table address width
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // saturated value 0..1.0, one integer bit
  localparam int VW = VALUE_FRAC_BITS + 1;
  // value times (count-1)
  localparam int PW = VW + COUNT_W;
  // rainbow position 10*x, up to 52.0
  localparam int XW = VW + 6;
  // signed width for rainbow terms
  localparam int SW = XW + 2;
  // unsigned width of the scaled rainbow product
  localparam int UW = SW + 6;
  // blend product width
  localparam int MW = VW + 9;

  localparam logic [VW-1:0]        ONE_V = VW'(1) << VALUE_FRAC_BITS;
  localparam logic signed [SW-1:0] ONE_S = SW'(ONE_V);
  localparam logic signed [SW-1:0] O10   = (ONE_S <<< 1) + (ONE_S <<< 3);
  localparam logic signed [SW-1:0] O20   = O10 <<< 1;
  localparam logic signed [SW-1:0] O30   = O10 + O20;
  localparam logic signed [SW-1:0] O40   = O20 <<< 1;
  localparam logic signed [SW-1:0] O50   = O40 + O10;

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic               color_mode;
  logic [1:0]         map_kind;
  logic [COUNT_W-1:0] entry_count;
  logic               invert_order;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= RST_COLOR_MODE;
      map_kind     <= RST_MAP_KIND;
      entry_count  <= RST_ENTRY_COUNT;
      invert_order <= RST_INVERT_ORDER;
    end else if (cfg_we) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_COLOR_MODE:   color_mode   <= pwdata[0];
        REG_MAP_KIND:     map_kind     <= pwdata[1:0];
        REG_ENTRY_COUNT:  entry_count  <= pwdata[COUNT_W-1:0];
        REG_INVERT_ORDER: invert_order <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_COLOR_MODE:   prdata = CFG_DATA_W'(color_mode);
      REG_MAP_KIND:     prdata = CFG_DATA_W'(map_kind);
      REG_ENTRY_COUNT:  prdata = CFG_DATA_W'(entry_count);
      REG_INVERT_ORDER: prdata = CFG_DATA_W'(invert_order);
      default:          prdata = '0;
    endcase
  end

  // entries in use: zero acts as one, clamp to the table depth
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] last;

  always_comb begin
    if (entry_count == '0) begin
      count = COUNT_W'(1);
    end else if (32'(entry_count) > TABLE_DEPTH) begin
      count = COUNT_W'(TABLE_DEPTH);
    end else begin
      count = entry_count;
    end
    last = count - COUNT_W'(1);
  end

  // ---------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------
  clut_state_t state;
  clut_state_t state_next;
  logic        accept;
  logic        tbl_we;
  logic        lookup_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && func_t'(func) == FUNC_LOOKUP) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: state_next = ST_READ;
      ST_READ: state_next = ST_MIX;
      ST_MIX:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    accept    = 1'b0;
    tbl_we    = 1'b0;
    lookup_go = 1'b0;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        accept    = start;
        tbl_we    = start && func_t'(func) == FUNC_WRITE
                    && 32'(entry_index) < TABLE_DEPTH;
        lookup_go = start && func_t'(func) == FUNC_LOOKUP;
      end
      ST_CALC, ST_READ, ST_MIX: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------
  // color table: one write port, two registered read ports
  // ---------------------------------------------------------------
  logic [23:0]   color_table [TABLE_DEPTH];
  logic [AW-1:0] rd_addr0;
  logic [AW-1:0] rd_addr1;
  logic [23:0]   rd_data0;
  logic [23:0]   rd_data1;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      color_table[AW'(entry_index)] <= {red_in, green_in, blue_in};
    end
    rd_data0 <= color_table[rd_addr0];
    rd_data1 <= color_table[rd_addr1];
  end

  // ---------------------------------------------------------------
  // step 1: take the sample
  // ---------------------------------------------------------------
  logic [23:0] sample;

  always_ff @(posedge clk) begin
    if (lookup_go) begin
      sample <= sample_value;
    end
  end

  // ---------------------------------------------------------------
  // step 2: saturate, scale by count-1, categorical index, gray level, rainbow position
  // ---------------------------------------------------------------
  logic [24:0]        sample_ext;
  logic [VW-1:0]      v_c;
  logic [PW-1:0]      pos_c;
  logic [24:0]        ip_c;
  logic [COUNT_W-1:0] cat_c;
  logic [XW-1:0]      x_c;
  logic [VW+7:0]      gray_prod;

  logic [PW-1:0]      pos;
  logic [COUNT_W-1:0] cat_i;
  logic [XW-1:0]      x_pos;
  logic [7:0]         gray;

  always_comb begin
    sample_ext = {1'b0, sample};
    v_c        = (sample_ext > 25'(ONE_V)) ? ONE_V : sample_ext[VW-1:0];
    pos_c      = PW'(v_c) * PW'(last);
    // categorical index uses the unsaturated integer part
    ip_c       = sample_ext >> VALUE_FRAC_BITS;
    cat_c      = (ip_c >= 25'(count)) ? last : ip_c[COUNT_W-1:0];
    // 10*x = 44*v + 8.0
    x_c        = XW'(v_c) * XW'(44) + (XW'(ONE_V) << 3);
    gray_prod  = ((VW + 8)'(v_c) << 8) - (VW + 8)'(v_c);
  end

  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      pos   <= pos_c;
      cat_i <= cat_c;
      x_pos <= x_c;
      gray  <= gray_prod[VALUE_FRAC_BITS+7:VALUE_FRAC_BITS];
    end
  end

  // ---------------------------------------------------------------
  // step 3: table addresses, rainbow channels
  // ---------------------------------------------------------------
  function automatic logic signed [SW-1:0] abs_diff(input logic signed [SW-1:0] a,
                                                    input logic signed [SW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // floor(num * 255 / 20.0) with num in value units, clamped to 0..255
  function automatic logic [7:0] rb_scale(input logic signed [SW-1:0] num);
    logic [UW-1:0] prod;
    logic [UW-1:0] q;
    prod = '0;
    q    = '0;
    if (num <= 0) begin
      return 8'd0;
    end
    prod = UW'(num[SW-2:0]) * UW'(51);
    q    = prod >> (VALUE_FRAC_BITS + 2);
    return (q > UW'(255)) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_slot(input logic [COUNT_W-1:0] li,
                                                 input logic [COUNT_W-1:0] lst,
                                                 input logic               inv);
    return inv ? lst - li : li;
  endfunction

  logic [PW-1:0]               pos_int;
  logic [COUNT_W-1:0]          li0;
  logic [COUNT_W-1:0]          li1;
  logic [COUNT_W-1:0]          lsel;
  logic signed [SW-1:0]        xs;
  logic [7:0]                  rb_r_c;
  logic [7:0]                  rb_g_c;
  logic [7:0]                  rb_b_c;

  logic                        has_next;
  logic [VALUE_FRAC_BITS-1:0]  frac;
  logic [7:0]                  rb_r;
  logic [7:0]                  rb_g;
  logic [7:0]                  rb_b;

  always_comb begin
    pos_int  = pos >> VALUE_FRAC_BITS;
    li0      = pos_int[COUNT_W-1:0];
    li1      = li0 + COUNT_W'(1);
    lsel     = (map_kind == MAP_CATEG) ? cat_i : li0;
    rd_addr0 = AW'(to_slot(lsel, last, invert_order));
    rd_addr1 = AW'(to_slot(li1, last, invert_order));

    xs     = SW'(x_pos);
    rb_r_c = rb_scale(O30 - abs_diff(xs, O40) - abs_diff(xs, O50));
    rb_g_c = rb_scale(O40 - abs_diff(xs, O20) - abs_diff(xs, O40));
    rb_b_c = rb_scale(O30 - abs_diff(xs, O10) - abs_diff(xs, O20));
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      has_next <= li0 < last;
      frac     <= pos[VALUE_FRAC_BITS-1:0];
      rb_r     <= rb_r_c;
      rb_g     <= rb_g_c;
      rb_b     <= rb_b_c;
    end
  end

  // ---------------------------------------------------------------
  // step 4: blend neighbors, pick the map, drive the result
  // ---------------------------------------------------------------
  logic [VW-1:0] w0;
  logic [MW-1:0] mix_sum [3];
  logic [7:0]    mix_ch  [3];
  logic [7:0]    res_r;
  logic [7:0]    res_g;
  logic [7:0]    res_b;

  always_comb begin
    w0 = ONE_V - VW'(frac);
    for (int k = 0; k < 3; k++) begin
      mix_sum[k] = MW'(rd_data0[8*(2-k) +: 8]) * MW'(w0)
                 + MW'(rd_data1[8*(2-k) +: 8]) * MW'(frac);
      mix_ch[k]  = mix_sum[k][VALUE_FRAC_BITS+7:VALUE_FRAC_BITS];
    end

    if (color_mode_t'(color_mode) == MODE_GRAY) begin
      res_r = gray;
      res_g = gray;
      res_b = gray;
    end else if (map_kind == MAP_RAINBOW) begin
      res_r = rb_r;
      res_g = rb_g;
      res_b = rb_b;
    end else if (map_kind == MAP_CATEG || !has_next) begin
      // categorical, or the table end at 1.0: entry as stored
      res_r = rd_data0[23:16];
      res_g = rd_data0[15:8];
      res_b = rd_data0[7:0];
    end else begin
      res_r = mix_ch[0];
      res_g = mix_ch[1];
      res_b = mix_ch[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= state == ST_MIX;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MIX) begin
      red   <= res_r;
      green <= res_g;
      blue  <= res_b;
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_done_after_mix: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_MIX))
    else $error("result strobe without a finished blend step");

  a_lookup_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && func_t'(func) == FUNC_LOOKUP) |-> ##4 done)
    else $error("lookup did not produce a result four cycles later");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && func_t'(func) == FUNC_WRITE) |=> !done)
    else $error("table write produced a result");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> state == ST_IDLE)
    else $error("table written while a lookup is in flight");

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(state == ST_MIX))
    else $error("sequencer left a lookup early");

endmodule
